// File: rtl/mfde_pkg.sv
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared constants, codes and types of the one-bit frame store draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

    localparam int FRAME_BYTES = 4096;
    localparam int FONT_BYTES  = 8192;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int FONT_AW     = $clog2(FONT_BYTES);
    // width of byte address arithmetic (frame pixel address, glyph font address)
    localparam int MEM_AW      = 17;
    localparam int CHAR_BASE   = 32;   // ' '
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_PIXEL    = 3'd0;
    localparam logic [2:0] OP_RECT     = 3'd1;
    localparam logic [2:0] OP_GLYPH    = 3'd2;
    localparam logic [2:0] OP_FONT_WR  = 3'd3;
    localparam logic [2:0] OP_FRAME_RD = 3'd4;

    localparam logic [2:0] REG_ROTATION      = 3'd0;
    localparam logic [2:0] REG_INVERT_COLOR  = 3'd1;
    localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd3;
    localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd4;
    localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd5;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [2:0] {
        K_NONE,
        K_PIXEL,
        K_RECT,
        K_GLYPH,
        K_FONT_WR,
        K_FRAME_RD
    } kind_t;

    typedef struct packed {
        logic [1:0] rotation;
        logic       invert_color;
        logic [7:0] canvas_width;
        logic [8:0] canvas_height;
        logic [5:0] glyph_width;
        logic [5:0] glyph_height;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [7:0]  lo_x;
        logic [7:0]  hi_x;
        logic [7:0]  lo_y;
        logic [7:0]  hi_y;
        logic        colored;
        logic [6:0]  char_code;
        logic [12:0] mem_addr;
        logic [7:0]  font_byte;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_stat_t;

endpackage

// File: rtl/mfde_ram.sv
// ----------------------------------------------------------------------------
// mfde_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/mfde_regs.sv
// ----------------------------------------------------------------------------
// mfde_regs
// APB configuration registers: rotation, color sense, canvas and glyph size.
// ----------------------------------------------------------------------------
module mfde_regs
    import mfde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t        cfg_reg;
    logic [2:0]  idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation      <= 2'd0;
            cfg_reg.invert_color  <= 1'b0;
            cfg_reg.canvas_width  <= 8'd96;
            cfg_reg.canvas_height <= 9'd200;
            cfg_reg.glyph_width   <= 6'd17;
            cfg_reg.glyph_height  <= 6'd24;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (idx)
                REG_ROTATION:      cfg_reg.rotation      <= pwdata[1:0];
                REG_INVERT_COLOR:  cfg_reg.invert_color  <= pwdata[0];
                REG_CANVAS_WIDTH:  cfg_reg.canvas_width  <= pwdata[7:0];
                REG_CANVAS_HEIGHT: cfg_reg.canvas_height <= pwdata[8:0];
                REG_GLYPH_WIDTH:   cfg_reg.glyph_width   <= pwdata[5:0];
                REG_GLYPH_HEIGHT:  cfg_reg.glyph_height  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROTATION:      prdata = {30'd0, cfg_reg.rotation};
            REG_INVERT_COLOR:  prdata = {31'd0, cfg_reg.invert_color};
            REG_CANVAS_WIDTH:  prdata = {24'd0, cfg_reg.canvas_width};
            REG_CANVAS_HEIGHT: prdata = {23'd0, cfg_reg.canvas_height};
            REG_GLYPH_WIDTH:   prdata = {26'd0, cfg_reg.glyph_width};
            REG_GLYPH_HEIGHT:  prdata = {26'd0, cfg_reg.glyph_height};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/mfde_front.sv
// ----------------------------------------------------------------------------
// mfde_front
// Accepts input transactions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mfde_front
    import mfde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [9:0]  pos_x,
    input  logic [9:0]  pos_y,
    input  logic [7:0]  corner_a_x,
    input  logic [7:0]  corner_a_y,
    input  logic [7:0]  corner_b_x,
    input  logic [7:0]  corner_b_y,
    input  logic        colored,
    input  logic [6:0]  char_code,
    input  logic [12:0] mem_addr,
    input  logic [7:0]  font_byte,
    input  back_stat_t  stat,
    output logic        cmd_valid,
    output cmd_t        cmd
);

    cmd_t       q_mem [QUEUE_DEPTH];
    cmd_t       cls;
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;

    always_comb
    begin
        cls.pos_x     = pos_x;
        cls.pos_y     = pos_y;
        cls.lo_x      = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
        cls.hi_x      = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
        cls.lo_y      = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
        cls.hi_y      = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;
        cls.colored   = colored;
        cls.char_code = char_code;
        cls.mem_addr  = mem_addr;
        cls.font_byte = font_byte;
        unique case (op)
            OP_PIXEL:    cls.kind = K_PIXEL;
            OP_RECT:     cls.kind = K_RECT;
            // glyph codes below space become no-op (K_NONE) commands
            OP_GLYPH:    cls.kind = (char_code < 7'(CHAR_BASE)) ? K_NONE : K_GLYPH;
            OP_FONT_WR:  cls.kind = K_FONT_WR;
            OP_FRAME_RD: cls.kind = K_FRAME_RD;
            default:     cls.kind = K_NONE;
        endcase
    end

    assign in_ready  = !stat.clearing && (count_reg != 2'(QUEUE_DEPTH));
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (stat.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(stat.pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: rtl/mfde_back.sv
// ----------------------------------------------------------------------------
// mfde_back
// Command sequencer: pixel read-modify-write, rectangle and glyph walks,
// font writes, frame reads, and the frame store clearing pass after reset.
// ----------------------------------------------------------------------------
module mfde_back
    import mfde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output back_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIX_MAP,
        S_PIX_MUL,
        S_PIX_RD,
        S_PIX_WR,
        S_GLY_PREP,
        S_GLY_BASE,
        S_GLY_FRD,
        S_GLY_FBIT,
        S_FRD_WAIT
    } state_t;

    state_t              state_reg;
    kind_t               kind_reg;
    logic                clearing_reg;
    logic [FRAME_AW-1:0] clr_cnt_reg;
    logic                out_valid_reg;
    logic [7:0]          read_data_reg;

    logic [10:0]         lx_reg;
    logic [10:0]         ly_reg;
    logic [7:0]          ax_reg;
    logic [8:0]          ay_reg;
    logic [17:0]         prod_reg;
    logic [FRAME_AW-1:0] waddr_reg;
    logic [2:0]          bit_reg;
    logic                set_reg;
    logic [7:0]          lo_y_reg;
    logic [7:0]          hi_x_reg;
    logic [7:0]          hi_y_reg;
    logic [9:0]          ox_reg;
    logic [9:0]          oy_reg;
    logic [6:0]          code_reg;
    logic [5:0]          gi_reg;
    logic [5:0]          gj_reg;
    logic [9:0]          gh_bpr_reg;
    logic [MEM_AW-1:0]   row_addr_reg;
    logic                font_ok_reg;

    logic [8:0]          eff_w;
    logic [8:0]          eff_h;
    logic [3:0]          bpr;
    logic [6:0]          gw_sum;
    logic                pop;

    logic                map_ok;
    logic [10:0]         map_ax;
    logic [10:0]         map_ay;
    logic [17:0]         pix_sum;
    logic [MEM_AW-1:0]   pix_addr;
    logic                pix_in;
    logic [MEM_AW-1:0]   font_a;
    logic                font_in;

    logic                adv_finish;
    state_t              adv_state;
    logic [10:0]         adv_lx;
    logic [10:0]         adv_ly;
    logic [5:0]          adv_gi;
    logic [5:0]          adv_gj;
    logic [MEM_AW-1:0]   adv_row;

    logic                fram_we;
    logic [FRAME_AW-1:0] fram_waddr;
    logic [7:0]          fram_wdata;
    logic [FRAME_AW-1:0] fram_raddr;
    logic [7:0]          fram_rdata;
    logic                font_we;
    logic [FONT_AW-1:0]  font_raddr;
    logic [7:0]          font_rdata;
    logic [MEM_AW-1:0]   cmd_addr;

    assign eff_w  = ({1'b0, cfg.canvas_width} + 9'd7) & 9'h1F8;
    assign eff_h  = cfg.canvas_height;
    assign gw_sum = {1'b0, cfg.glyph_width} + 7'd7;
    assign bpr    = gw_sum[6:3];

    assign pop       = (state_reg == S_IDLE) && cmd_valid && !out_valid_reg && !clearing_reg;
    assign stat.pop      = pop;
    assign stat.clearing = clearing_reg;
    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign cmd_addr      = MEM_AW'(cmd.mem_addr);

    // rotation and bounds of the logical point
    always_comb
    begin
        map_ax = lx_reg;
        map_ay = ly_reg;
        map_ok = 1'b0;
        unique case (cfg.rotation)
            ROT_0:
            begin
                map_ok = (lx_reg < 11'(eff_w)) && (ly_reg < 11'(eff_h));
            end
            ROT_90:
            begin
                map_ok = (lx_reg < 11'(eff_h)) && (ly_reg < 11'(eff_w));
                map_ax = 11'(eff_w) - ly_reg;
                map_ay = lx_reg;
            end
            ROT_180:
            begin
                map_ok = (lx_reg < 11'(eff_w)) && (ly_reg < 11'(eff_h));
                map_ax = 11'(eff_w) - lx_reg;
                map_ay = 11'(eff_h) - ly_reg;
            end
            ROT_270:
            begin
                map_ok = (lx_reg < 11'(eff_h)) && (ly_reg < 11'(eff_w));
                map_ax = ly_reg;
                map_ay = 11'(eff_h) - lx_reg;
            end
            default: ;
        endcase
        map_ok = map_ok && (map_ax < 11'(eff_w)) && (map_ay < 11'(eff_h));
    end

    assign pix_sum  = {10'd0, ax_reg} + prod_reg;
    assign pix_addr = MEM_AW'(pix_sum >> 3);
    assign pix_in   = 32'(pix_addr) < 32'(FRAME_BYTES);
    assign font_a   = row_addr_reg + MEM_AW'(gi_reg >> 3);
    assign font_in  = 32'(font_a) < 32'(FONT_BYTES);

    // next step after one pixel is done or dropped
    always_comb
    begin
        adv_finish = 1'b0;
        adv_state  = S_PIX_MAP;
        adv_lx     = lx_reg;
        adv_ly     = ly_reg;
        adv_gi     = gi_reg;
        adv_gj     = gj_reg;
        adv_row    = row_addr_reg;
        case (kind_reg)
            K_RECT:
            begin
                if (ly_reg[7:0] == hi_y_reg)
                begin
                    adv_ly = 11'(lo_y_reg);
                    if (lx_reg[7:0] == hi_x_reg)
                    begin
                        adv_finish = 1'b1;
                    end
                    else
                    begin
                        adv_lx = lx_reg + 11'd1;
                    end
                end
                else
                begin
                    adv_ly = ly_reg + 11'd1;
                end
            end
            K_GLYPH:
            begin
                adv_state = S_GLY_FRD;
                if (gi_reg == cfg.glyph_width - 6'd1)
                begin
                    adv_gi = 6'd0;
                    if (gj_reg == cfg.glyph_height - 6'd1)
                    begin
                        adv_finish = 1'b1;
                    end
                    else
                    begin
                        adv_gj  = gj_reg + 6'd1;
                        adv_row = row_addr_reg + MEM_AW'(bpr);
                    end
                end
                else
                begin
                    adv_gi = gi_reg + 6'd1;
                end
            end
            default:
            begin
                adv_finish = 1'b1;
            end
        endcase
        if (adv_finish)
        begin
            adv_state = S_IDLE;
        end
    end

    // memory ports
    always_comb
    begin
        fram_we    = 1'b0;
        fram_waddr = waddr_reg;
        fram_wdata = set_reg ? (fram_rdata | (8'd1 << bit_reg))
                             : (fram_rdata & ~(8'd1 << bit_reg));
        if (clearing_reg)
        begin
            fram_we    = 1'b1;
            fram_waddr = clr_cnt_reg;
            fram_wdata = 8'd0;
        end
        else if (state_reg == S_PIX_WR)
        begin
            fram_we = 1'b1;
        end
        fram_raddr = (state_reg == S_PIX_RD) ? pix_addr[FRAME_AW-1:0]
                                             : cmd_addr[FRAME_AW-1:0];
        font_raddr = font_a[FONT_AW-1:0];
        font_we    = pop && (cmd.kind == K_FONT_WR) && (32'(cmd_addr) < 32'(FONT_BYTES));
    end

    mfde_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (fram_waddr),
        .wdata (fram_wdata),
        .raddr (fram_raddr),
        .rdata (fram_rdata)
    );

    mfde_ram #(
        .WIDTH (8),
        .DEPTH (FONT_BYTES)
    ) u_font_ram (
        .clk   (clk),
        .we    (font_we),
        .waddr (cmd_addr[FONT_AW-1:0]),
        .wdata (cmd.font_byte),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_NONE;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            read_data_reg <= 8'd0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + FRAME_AW'(1);
                if (clr_cnt_reg == FRAME_AW'(FRAME_BYTES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        kind_reg <= cmd.kind;
                        set_reg  <= cfg.invert_color ? cmd.colored : !cmd.colored;
                        lo_y_reg <= cmd.lo_y;
                        hi_x_reg <= cmd.hi_x;
                        hi_y_reg <= cmd.hi_y;
                        ox_reg   <= cmd.pos_x;
                        oy_reg   <= cmd.pos_y;
                        code_reg <= cmd.char_code;
                        unique case (cmd.kind)
                            K_PIXEL:
                            begin
                                lx_reg    <= 11'(cmd.pos_x);
                                ly_reg    <= 11'(cmd.pos_y);
                                state_reg <= S_PIX_MAP;
                            end
                            K_RECT:
                            begin
                                lx_reg    <= 11'(cmd.lo_x);
                                ly_reg    <= 11'(cmd.lo_y);
                                state_reg <= S_PIX_MAP;
                            end
                            K_GLYPH:
                            begin
                                state_reg <= S_GLY_PREP;
                            end
                            K_FRAME_RD:
                            begin
                                if (32'(cmd_addr) < 32'(FRAME_BYTES))
                                begin
                                    state_reg <= S_FRD_WAIT;
                                end
                                else
                                begin
                                    out_valid_reg <= 1'b1;
                                    read_data_reg <= 8'd0;
                                end
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                read_data_reg <= 8'd0;
                            end
                        endcase
                    end
                end
                S_PIX_MAP:
                begin
                    ax_reg <= map_ax[7:0];
                    ay_reg <= map_ay[8:0];
                    if (map_ok)
                    begin
                        state_reg <= S_PIX_MUL;
                    end
                    else
                    begin
                        state_reg <= adv_state;
                        lx_reg    <= adv_lx;
                        ly_reg    <= adv_ly;
                        gi_reg    <= adv_gi;
                        gj_reg    <= adv_gj;
                        row_addr_reg <= adv_row;
                        if (adv_finish)
                        begin
                            out_valid_reg <= 1'b1;
                            read_data_reg <= 8'd0;
                        end
                    end
                end
                S_PIX_MUL:
                begin
                    prod_reg  <= ay_reg * eff_w;
                    state_reg <= S_PIX_RD;
                end
                S_PIX_RD:
                begin
                    waddr_reg <= pix_addr[FRAME_AW-1:0];
                    bit_reg   <= ax_reg[2:0];
                    if (pix_in)
                    begin
                        state_reg <= S_PIX_WR;
                    end
                    else
                    begin
                        state_reg    <= adv_state;
                        lx_reg       <= adv_lx;
                        ly_reg       <= adv_ly;
                        gi_reg       <= adv_gi;
                        gj_reg       <= adv_gj;
                        row_addr_reg <= adv_row;
                        if (adv_finish)
                        begin
                            out_valid_reg <= 1'b1;
                            read_data_reg <= 8'd0;
                        end
                    end
                end
                S_PIX_WR:
                begin
                    state_reg    <= adv_state;
                    lx_reg       <= adv_lx;
                    ly_reg       <= adv_ly;
                    gi_reg       <= adv_gi;
                    gj_reg       <= adv_gj;
                    row_addr_reg <= adv_row;
                    if (adv_finish)
                    begin
                        out_valid_reg <= 1'b1;
                        read_data_reg <= 8'd0;
                    end
                end
                S_GLY_PREP:
                begin
                    gh_bpr_reg <= cfg.glyph_height * bpr;
                    if (cfg.glyph_width == 6'd0 || cfg.glyph_height == 6'd0)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        read_data_reg <= 8'd0;
                    end
                    else
                    begin
                        state_reg <= S_GLY_BASE;
                    end
                end
                S_GLY_BASE:
                begin
                    row_addr_reg <= MEM_AW'((code_reg - 7'(CHAR_BASE)) * gh_bpr_reg);
                    gi_reg       <= 6'd0;
                    gj_reg       <= 6'd0;
                    state_reg    <= S_GLY_FRD;
                end
                S_GLY_FRD:
                begin
                    font_ok_reg <= font_in;
                    state_reg   <= S_GLY_FBIT;
                end
                S_GLY_FBIT:
                begin
                    if (font_ok_reg && font_rdata[3'd7 - gi_reg[2:0]])
                    begin
                        lx_reg    <= 11'(ox_reg) + 11'(gi_reg);
                        ly_reg    <= 11'(oy_reg) + 11'(gj_reg);
                        state_reg <= S_PIX_MAP;
                    end
                    else
                    begin
                        state_reg    <= adv_state;
                        gi_reg       <= adv_gi;
                        gj_reg       <= adv_gj;
                        row_addr_reg <= adv_row;
                        if (adv_finish)
                        begin
                            out_valid_reg <= 1'b1;
                            read_data_reg <= 8'd0;
                        end
                    end
                end
                S_FRD_WAIT:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b1;
                    read_data_reg <= fram_rdata;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/mono_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// One-bit frame store drawing engine: pixel, rectangle, glyph, font write,
// frame read, with rotation, bounds check and selectable color sense.
// ----------------------------------------------------------------------------
// Each accepted item yields one result transaction. A pixel passes the map,
// multiply, read and write states; a rectangle walks these for each pixel, and
// a pixel out of range leaves at the map state. A glyph reads its font bit for
// each glyph pixel and sends each set pixel through the pixel states. A
// two-entry queue accepts items while one works.
// After reset a clearing pass zeroes every frame store byte; no item is taken.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine
    import mfde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [9:0]  pos_x,
    input  logic [9:0]  pos_y,
    input  logic [7:0]  corner_a_x,
    input  logic [7:0]  corner_a_y,
    input  logic [7:0]  corner_b_x,
    input  logic [7:0]  corner_b_y,
    input  logic        colored,
    input  logic [6:0]  char_code,
    input  logic [12:0] mem_addr,
    input  logic [7:0]  font_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data
);

    cfg_t       cfg;
    back_stat_t stat;
    logic       cmd_valid;
    cmd_t       cmd;

    mfde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .corner_a_x (corner_a_x),
        .corner_a_y (corner_a_y),
        .corner_b_x (corner_b_x),
        .corner_b_y (corner_b_y),
        .colored    (colored),
        .char_code  (char_code),
        .mem_addr   (mem_addr),
        .font_byte  (font_byte),
        .stat       (stat),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    mfde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data)
    );

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) stat.clearing |-> !in_ready
    ) else $error("input accepted during frame store clearing pass");

    a_pop_needs_free_output: assert property (
        @(posedge clk) disable iff (!rst_n) stat.pop |-> (!out_valid && cmd_valid)
    ) else $error("command started while a result still waits");

    a_result_zero_unless_read: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stat.pop && cmd.kind != K_FRAME_RD) |=> (read_data == 8'd0 || !out_valid)
    ) else $error("non-read command produced nonzero read data");

endmodule
